// ----- rtl/compass_heading_filter_unit_defines.svh -----
// Assertion macros used by the compass heading filter unit.
`ifndef COMPASS_HEADING_FILTER_UNIT_DEFINES_SVH
`define COMPASS_HEADING_FILTER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CHF_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define CHF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/chf_pkg.sv -----
`default_nettype none
package chf_pkg;
    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W = 5;
    localparam int XW = 20;
    localparam int ZW = 24;
    localparam int ANG_W = 15;
    localparam int FULL_TURN = 23040;
    localparam int HALF_TURN = 11520;
    localparam int Z_HALF = 180 * 16384;

    localparam logic CFG_DECLINATION = 1'b0;
    localparam logic CFG_GAIN = 1'b1;

    typedef struct packed {
        logic                 valid;
        logic                 ok;
        logic                 zero;
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
    } cordic_t;

    // atan(2^-i) in degrees, scaled by 16384.
    function automatic logic signed [ZW-1:0] atan_lut(input logic [STEP_W-1:0] i);
        logic signed [ZW-1:0] v;
        begin
            case (i)
                5'd0:    v = 24'sd737280;
                5'd1:    v = 24'sd435242;
                5'd2:    v = 24'sd229970;
                5'd3:    v = 24'sd116736;
                5'd4:    v = 24'sd58595;
                5'd5:    v = 24'sd29326;
                5'd6:    v = 24'sd14667;
                5'd7:    v = 24'sd7334;
                5'd8:    v = 24'sd3667;
                5'd9:    v = 24'sd1833;
                5'd10:   v = 24'sd917;
                5'd11:   v = 24'sd458;
                5'd12:   v = 24'sd229;
                5'd13:   v = 24'sd115;
                5'd14:   v = 24'sd57;
                5'd15:   v = 24'sd29;
                5'd16:   v = 24'sd14;
                5'd17:   v = 24'sd7;
                5'd18:   v = 24'sd4;
                5'd19:   v = 24'sd2;
                5'd20:   v = 24'sd1;
                default: v = 24'sd0;
            endcase
            return v;
        end
    endfunction
endpackage
`default_nettype wire

// ----- rtl/chf_cell.sv -----
`default_nettype none
module chf_cell (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic [chf_pkg::STEP_W-1:0]      step_idx,
    input  wire chf_pkg::cordic_t                cell_in,
    output chf_pkg::cordic_t                     cell_out
);
    import chf_pkg::*;

    cordic_t cell_reg;
    cordic_t cell_next;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb begin
        xs = cell_in.x >>> step_idx;
        ys = cell_in.y >>> step_idx;
        cell_next = cell_in;
        if (!cell_in.y[XW-1]) begin
            cell_next.x = cell_in.x + ys;
            cell_next.y = cell_in.y - xs;
            cell_next.z = cell_in.z + atan_lut(step_idx);
        end else begin
            cell_next.x = cell_in.x - ys;
            cell_next.y = cell_in.y + xs;
            cell_next.z = cell_in.z - atan_lut(step_idx);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_reg.valid <= 1'b0;
        end else begin
            cell_reg <= cell_next;
        end
    end

    assign cell_out = cell_reg;
endmodule
`default_nettype wire

// ----- rtl/chf_cordic_row.sv -----
`default_nettype none
module chf_cordic_row (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire chf_pkg::cordic_t row_in,
    output chf_pkg::cordic_t      row_out
);
    import chf_pkg::*;

    cordic_t link [CORDIC_STEPS+1];

    assign link[0] = row_in;

    for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cell
        chf_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .step_idx (STEP_W'(g)),
            .cell_in  (link[g]),
            .cell_out (link[g+1])
        );
    end

    assign row_out = link[CORDIC_STEPS];
endmodule
`default_nettype wire

// ----- rtl/compass_heading_filter_unit.sv -----
`default_nettype none
// Compass heading filter. Each word on the slave side carries one magnetometer
// X/Y sample and a sample_ok flag; each gives exactly one word on the master
// side holding the low-pass filtered heading in 1/64 degree units (0..23039).
// The heading is found by a row of 16 CORDIC cells, one rotation per cell and
// cycle, followed by three arithmetic stages (rounding and declination, wrapped
// difference times gain, state update). The block holds one item at a time: a
// new word is taken only once the last result has moved into the output register;
// a finished result may wait in the output register while the next word is
// already in work. Configuration is written through a plain write port.
module compass_heading_filter_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_index,
    input  wire logic [14:0] cfg_wdata,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // mag_x[15:0], mag_y[31:16]
    input  wire logic        s_tuser,   // sample_ok
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // heading[14:0], zero pad[15]
);
    import chf_pkg::*;

    `include "compass_heading_filter_unit_defines.svh"

    logic signed [14:0] decl_reg;
    logic [8:0]         gain_reg;
    logic [ANG_W-1:0]   state_reg;
    logic [ANG_W-1:0]   state_next;
    logic               busy_reg;
    logic               m_valid_reg;
    logic [ANG_W-1:0]   m_data_reg;

    cordic_t row_in_reg;
    cordic_t row_in_next;
    cordic_t row_out;

    logic               p1_valid_reg;
    logic               p1_ok_reg;
    logic [ANG_W-1:0]   p1_raw_reg;
    logic [ANG_W-1:0]   p1_raw_next;
    logic               p2_valid_reg;
    logic               p2_ok_reg;
    logic signed [26:0] p2_prod_reg;
    logic signed [26:0] p2_prod_next;

    logic signed [XW-1:0] sx;
    logic signed [XW-1:0] sy;
    logic signed [ZW-1:0] zr_full;
    logic signed [16:0]   zr;
    logic signed [16:0]   rsum;
    logic signed [16:0]   diff;
    logic signed [9:0]    alpha;
    logic signed [18:0]   step;
    logic signed [19:0]   usum;
    logic                 s_accept;
    logic                 commit;

    assign s_tready = !busy_reg;
    assign s_accept = s_tvalid && s_tready;
    assign commit   = p2_valid_reg && (!m_valid_reg || m_tready);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_data_reg};

    // Fold the vector into the right half plane before the rotations.
    always_comb begin
        sx = XW'(signed'(s_tdata[15:0]));
        sy = XW'(signed'(s_tdata[31:16]));
        row_in_next.valid = s_accept;
        row_in_next.ok    = s_tuser;
        row_in_next.zero  = (sx == '0) && (sy == '0);
        if (sx[XW-1]) begin
            row_in_next.x = -sx;
            row_in_next.y = -sy;
            row_in_next.z = ZW'(Z_HALF);
        end else begin
            row_in_next.x = sx;
            row_in_next.y = sy;
            row_in_next.z = '0;
        end
    end

    chf_cordic_row u_row (
        .aclk    (aclk),
        .aresetn (aresetn),
        .row_in  (row_in_reg),
        .row_out (row_out)
    );

    always_comb begin
        zr_full = (row_out.z + ZW'(128)) >>> 8;
        zr = row_out.zero ? 17'sd0 : zr_full[16:0];
        rsum = zr + 17'(decl_reg);
        if (rsum < 0) begin
            p1_raw_next = ANG_W'(rsum + 17'sd23040);
        end else if (rsum >= 17'sd23040) begin
            p1_raw_next = ANG_W'(rsum - 17'sd23040);
        end else begin
            p1_raw_next = ANG_W'(rsum);
        end
    end

    always_comb begin
        alpha = (gain_reg > 9'd256) ? 10'sd256 : signed'({1'b0, gain_reg});
        diff = signed'({2'b00, p1_raw_reg}) - signed'({2'b00, state_reg});
        if (diff > 17'sd11520) begin
            diff = diff - 17'sd23040;
        end else if (diff < -17'sd11520) begin
            diff = diff + 17'sd23040;
        end
        p2_prod_next = 27'(alpha) * 27'(diff);
    end

    always_comb begin
        step = p2_prod_reg[26:8];
        usum = signed'({5'b0, state_reg}) + 20'(step);
        if (usum < 0) begin
            state_next = ANG_W'(usum + 20'sd23040);
        end else if (usum >= 20'sd23040) begin
            state_next = ANG_W'(usum - 20'sd23040);
        end else begin
            state_next = ANG_W'(usum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            decl_reg         <= 15'sd148;
            gain_reg         <= 9'd154;
            state_reg        <= '0;
            busy_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
            p1_valid_reg     <= 1'b0;
            p2_valid_reg     <= 1'b0;
            row_in_reg.valid <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_DECLINATION: decl_reg <= signed'(cfg_wdata);
                    CFG_GAIN:        gain_reg <= cfg_wdata[8:0];
                    default:         ;
                endcase
            end
            row_in_reg <= row_in_next;
            p1_valid_reg <= row_out.valid;
            p1_ok_reg    <= row_out.ok;
            p1_raw_reg   <= p1_raw_next;
            if (p1_valid_reg) begin
                p2_valid_reg <= 1'b1;
                p2_ok_reg    <= p1_ok_reg;
                p2_prod_reg  <= p2_prod_next;
            end else if (commit) begin
                p2_valid_reg <= 1'b0;
            end
            if (s_accept) begin
                busy_reg <= 1'b1;
            end else if (commit) begin
                busy_reg <= 1'b0;
            end
            if (commit) begin
                m_valid_reg <= 1'b1;
                if (p2_ok_reg) begin
                    state_reg  <= state_next;
                    m_data_reg <= state_next;
                end else begin
                    m_data_reg <= state_reg;
                end
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    `CHF_ASSERT_NEXT(a_accept_busy, s_accept, busy_reg, "accepted word did not mark busy")
    `CHF_ASSERT_NOW(a_state_range, 1'b1, state_reg < ANG_W'(FULL_TURN), "heading out of range")
    `CHF_ASSERT_NOW(a_p2_busy, p2_valid_reg, busy_reg, "result pending while idle")
    `CHF_ASSERT_NOW(a_row_busy, row_out.valid, busy_reg && !p2_valid_reg,
        "cordic row output with no matching item")
endmodule
`default_nettype wire
